[design/lse_pkg.sv]
// Shared constants, codes and types for the LIFO stack engine.
package lse_pkg;

   // Stack geometry
   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Transaction field widths
   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   // Width that holds both a position and a fill count for comparison
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_POP     = 3'd1,
      OP_PEEK    = 3'd2,
      OP_CHANGE  = 3'd3,
      OP_DISPLAY = 3'd4
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      SM_IDLE,
      SM_READ,
      SM_DISP
   } state_type;

endpackage

[design/lse_if.sv]
// Valid/ready channel interfaces for stack requests and responses.
interface lse_req_if;
   import lse_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          req_type;
   logic signed [WORD_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input value, input position,
                   output ready);
endinterface

interface lse_rsp_if;
   import lse_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [WORD_W-1:0] data;
   logic                     last;

   modport source (output valid, output status, output data, output last,
                   input ready);
   modport sink   (input valid, input status, input data, input last,
                   output ready);
endinterface

[design/lifo_stack_engine.sv]
// LIFO stack engine: a bounded stack of signed words held in one synchronous memory.
//
// Each request transaction carries one operation: push, pop, peek, change (overwrite
// a one-based position from the bottom) or display (every entry, top to bottom, last
// flag on the bottom one). Push, change, every error case and an unknown code finish
// in the accept cycle; an unknown code is dropped without a response. Pop and peek
// read the entry memory in the accept cycle and respond from its registered read
// data in the read state. Display sends one response per cycle while the response
// side is ready. A new request is taken only when the controller is idle and the
// response register is empty or being drained in that cycle. The memory needs no
// clearing after reset; only entries below the fill count are ever read.
module lifo_stack_engine (
   input  logic       clock,
   input  logic       reset,
   lse_req_if.sink    req_port,
   lse_rsp_if.source  rsp_port
);
   import lse_pkg::*;

   // Entry memory with registered read data
   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [WORD_W-1:0] wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;

   // Control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;

   // Response register
   logic                     out_valid_ff;
   status_type               out_status_ff;
   logic signed [WORD_W-1:0] out_data_ff;
   logic                     out_last_ff;
   logic                     out_load;
   status_type               out_status;
   logic signed [WORD_W-1:0] out_data;
   logic                     out_last;

   // Decode helpers
   logic             out_free;
   logic             accept;
   logic             is_empty;
   logic             is_full;
   logic             pos_bad;
   logic [ADDR_W-1:0] top_addr;

   assign out_free = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == SM_IDLE) && out_free;
   assign accept   = req_port.valid && req_port.ready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign pos_bad  = (req_port.position == '0) ||
                     (CMP_W'(req_port.position) > CMP_W'(count_ff));
   assign top_addr = ADDR_W'(count_ff - 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SM_IDLE: begin
            if (accept && !is_empty) begin
               if ((req_port.req_type == OP_POP) || (req_port.req_type == OP_PEEK)) begin
                  state_in = SM_READ;
               end else if (req_port.req_type == OP_DISPLAY) begin
                  state_in = SM_DISP;
               end
            end
         end
         SM_READ: begin
            if (out_free) begin
               state_in = SM_IDLE;
            end
         end
         SM_DISP: begin
            if (out_free && (idx_ff == '0)) begin
               state_in = SM_IDLE;
            end
         end
         default: state_in = SM_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = req_port.value;
      rd_en      = 1'b0;
      rd_addr    = top_addr;
      count_in   = count_ff;
      idx_in     = idx_ff;
      out_load   = 1'b0;
      out_status = STAT_OK;
      out_data   = '0;
      out_last   = 1'b1;
      case (state_ff)
         SM_IDLE: begin
            if (accept) begin
               case (req_port.req_type)
                  OP_PUSH: begin
                     out_load = 1'b1;
                     if (is_full) begin
                        out_status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_EMPTY;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  OP_CHANGE: begin
                     out_load = 1'b1;
                     if (is_empty) begin
                        out_status = STAT_EMPTY;
                     end else if (pos_bad) begin
                        out_status = STAT_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(req_port.position - 1'b1);
                     end
                  end
                  OP_DISPLAY: begin
                     if (is_empty) begin
                        out_load   = 1'b1;
                        out_status = STAT_EMPTY;
                     end else begin
                        rd_en  = 1'b1;
                        idx_in = top_addr;
                     end
                  end
                  default: begin
                     // unknown code: dropped without a response
                  end
               endcase
            end
         end
         SM_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = rd_data_ff;
            end
         end
         SM_DISP: begin
            // one entry per cycle while the response register is free, walking down from the top
            if (out_free) begin
               out_load = 1'b1;
               out_data = rd_data_ff;
               out_last = (idx_ff == '0);
               if (idx_ff != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - 1'b1;
                  idx_in  = idx_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory; reads and writes never fall in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SM_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (out_load) begin
         out_status_ff <= out_status;
         out_data_ff   <= out_data;
         out_last_ff   <= out_last;
      end
   end

   assign rsp_port.valid  = out_valid_ff;
   assign rsp_port.status = out_status_ff;
   assign rsp_port.data   = out_data_ff;
   assign rsp_port.last   = out_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above stack depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_port.req_type == OP_PUSH) && !is_full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the stack");

   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SM_DISP) |-> !is_empty)
      else $error("display walk on an empty stack");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the LIFO stack engine: random traffic against a stack predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lse_pkg::*;

   localparam int OP_CODE_MAX   = (1 << OP_W) - 1;
   localparam int RAND_REQS     = 410;
   localparam int DRAIN_EVERY   = 100;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 24;
   localparam int REPORT_MAX    = 10;
   localparam int RX_PHASE_LEN  = 50;

   typedef struct {
      logic [OP_W-1:0]          kind;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         pos;
      bit                       drain;  // hold off until every response is back
   } stack_req_type;

   typedef struct {
      status_type               status;
      logic signed [WORD_W-1:0] data;
      logic                     last;
   } stack_rsp_type;

   // Receiver stall patterns
   typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_type;

   logic clock;
   logic reset;

   lse_req_if req_bus ();
   lse_rsp_if rsp_bus ();

   lifo_stack_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Predictor state
   logic signed [WORD_W-1:0] stack_mem [DEPTH];
   int                       stack_fill;

   stack_req_type req_backlog_q[$];
   stack_rsp_type awaited_rsp_q[$];

   int  total_reqs;
   int  accepted_count;
   int  mismatch_count;
   int  cycle_count;
   int  gen_fill;
   logic req_taken;

   // Clock, 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void await_rsp(status_type status, logic signed [WORD_W-1:0] data,
                                     logic last);
      stack_rsp_type r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      awaited_rsp_q.push_back(r);
   endfunction

   // Stack predictor: updates the model and queues the responses of one transaction
   function automatic void stack_predict(logic [OP_W-1:0] kind, logic signed [WORD_W-1:0] word,
                                         logic [POS_W-1:0] pos);
      int k;
      case (kind)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               await_rsp(STAT_FULL, '0, 1'b1);
            end else begin
               stack_mem[stack_fill] = word;
               stack_fill++;
               await_rsp(STAT_OK, '0, 1'b1);
            end
         end
         OP_POP: begin
            if (stack_fill == 0) begin
               await_rsp(STAT_EMPTY, '0, 1'b1);
            end else begin
               stack_fill--;
               await_rsp(STAT_OK, stack_mem[stack_fill], 1'b1);
            end
         end
         OP_PEEK: begin
            if (stack_fill == 0) await_rsp(STAT_EMPTY, '0, 1'b1);
            else await_rsp(STAT_OK, stack_mem[stack_fill-1], 1'b1);
         end
         OP_CHANGE: begin
            if (stack_fill == 0) begin
               await_rsp(STAT_EMPTY, '0, 1'b1);
            end else if (pos == 0 || int'(pos) > stack_fill) begin
               await_rsp(STAT_RANGE, '0, 1'b1);
            end else begin
               stack_mem[pos-1] = word;
               await_rsp(STAT_OK, '0, 1'b1);
            end
         end
         OP_DISPLAY: begin
            if (stack_fill == 0) begin
               await_rsp(STAT_EMPTY, '0, 1'b1);
            end else begin
               // top to bottom, last flag on the bottom entry
               for (k = stack_fill - 1; k >= 0; k--) begin
                  await_rsp(STAT_OK, stack_mem[k], k == 0);
               end
            end
         end
         default: begin
            // unknown code: ignored, no response
         end
      endcase
   endfunction

   // Queue one request; also tracks the fill level the sequence will reach
   task automatic add_req(logic [OP_W-1:0] kind, logic signed [WORD_W-1:0] word,
                          logic [POS_W-1:0] pos, bit drain);
      stack_req_type r;
      r.kind  = kind;
      r.word  = word;
      r.pos   = pos;
      r.drain = drain;
      req_backlog_q.push_back(r);
      total_reqs++;
      if (kind == OP_PUSH && gen_fill < DEPTH) gen_fill++;
      if (kind == OP_POP && gen_fill > 0) gen_fill--;
   endtask

   // Random word with the extremes mixed in
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return {1'b0, {(WORD_W-1){1'b1}}};
         3: return {1'b1, {(WORD_W-1){1'b0}}};
         default: return $urandom;
      endcase
   endfunction

   // Request driver: bursts with random gaps, changes at the falling edge
   int burst_left;
   int gap_left;

   always @(negedge clock) begin : drive_proc
      stack_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         // hold the transaction until it is taken
      end else if (gap_left != 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
      end else if (req_backlog_q.size() == 0 ||
                   (req_backlog_q[0].drain && awaited_rsp_q.size() != 0)) begin
         req_bus.valid <= 1'b0;
      end else begin
         nxt = req_backlog_q.pop_front();
         req_bus.valid    <= 1'b1;
         req_bus.req_type <= nxt.kind;
         req_bus.value    <= nxt.word;
         req_bus.position <= nxt.pos;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end
   end

   // Response ready: stall pattern chosen anew at the start of each phase
   rx_mode_type rx_mode;
   int          rx_phase;

   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_phase = RX_PHASE_LEN;
         case ($urandom_range(0, 2))
            0: rx_mode = RX_OPEN;
            1: rx_mode = RX_HALF;
            default: rx_mode = RX_SPARSE;
         endcase
      end
      rx_phase--;
      case (rx_mode)
         RX_OPEN: rsp_bus.ready <= 1'b1;
         RX_HALF: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Monitor: predict on each accepted request, then check each accepted response
   always @(posedge clock) begin : watch_proc
      stack_rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_rsp_q.size());
         $display("** lifo_stack_engine: FAILED **");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            stack_predict(req_bus.req_type, req_bus.value, req_bus.position);
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected response status=%0d data=%0d last=%0b",
                           $realtime, rsp_bus.status, rsp_bus.data, rsp_bus.last);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.data !== want.data ||
                   rsp_bus.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"%0t: mismatch exp status=%0d data=%0d last=%0b,",
                               " got status=%0d data=%0d last=%0b"},
                              $realtime, want.status, want.data, want.last,
                              rsp_bus.status, rsp_bus.data, rsp_bus.last);
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin : main_proc
      int counted;
      int phase_left;
      int push_bias;
      int pick;
      logic [POS_W-1:0] pos;
      bit drain;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.value    = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      req_taken        = 1'b0;
      stack_fill       = 0;
      gen_fill         = 0;
      total_reqs       = 0;
      accepted_count   = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      burst_left       = 0;
      gap_left         = 0;
      rx_phase         = 0;
      rx_mode          = RX_OPEN;

      // Directed: empty cases, word extremes, bad positions, display, unknown codes
      add_req(OP_POP,     pick_word(), 5'd1, 1'b0);
      add_req(OP_PEEK,    pick_word(), 5'd1, 1'b0);
      add_req(OP_CHANGE,  pick_word(), 5'd1, 1'b0);
      add_req(OP_DISPLAY, pick_word(), 5'd1, 1'b0);
      add_req(OP_PUSH,    32'sh7FFF_FFFF, 5'd0, 1'b0);
      add_req(OP_PUSH,    32'sh8000_0000, 5'd0, 1'b0);
      add_req(OP_PUSH,    -32'sd1, 5'd0, 1'b0);
      add_req(OP_PUSH,    32'sd0, 5'd31, 1'b0);
      add_req(OP_PEEK,    pick_word(), 5'd0, 1'b0);
      add_req(OP_CHANGE,  pick_word(), 5'd0, 1'b0);
      add_req(OP_CHANGE,  pick_word(), 5'd5, 1'b0);
      add_req(OP_CHANGE,  pick_word(), 5'd31, 1'b0);
      add_req(OP_CHANGE,  32'sh5A5A_A5A5, 5'd1, 1'b0);
      add_req(OP_CHANGE,  32'shFFFF_0000, 5'd4, 1'b0);
      add_req(OP_DISPLAY, pick_word(), 5'd0, 1'b0);
      add_req(OP_POP,     pick_word(), 5'd0, 1'b0);
      add_req(OP_PEEK,    pick_word(), 5'd0, 1'b0);
      add_req(OP_W'(OP_DISPLAY + 1), pick_word(), 5'd2, 1'b0);
      add_req(OP_W'(OP_DISPLAY + 2), pick_word(), 5'd2, 1'b0);
      add_req(OP_W'(OP_CODE_MAX), pick_word(), 5'd2, 1'b0);
      add_req(OP_POP,     pick_word(), 5'd0, 1'b0);
      add_req(OP_POP,     pick_word(), 5'd0, 1'b0);
      add_req(OP_POP,     pick_word(), 5'd0, 1'b0);
      add_req(OP_POP,     pick_word(), 5'd0, 1'b0);

      // Random: phases that lean toward filling or draining the stack
      counted    = 0;
      phase_left = 0;
      push_bias  = 50;
      while (counted < RAND_REQS) begin
         drain = (counted % DRAIN_EVERY == 0);
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_bias = 15;
               1: push_bias = 50;
               default: push_bias = 85;
            endcase
            phase_left = $urandom_range(20, 50);
         end
         phase_left--;
         if (gen_fill > 0 && $urandom_range(0, 9) < 7)
            pos = POS_W'($urandom_range(1, gen_fill));
         else
            pos = POS_W'($urandom_range(0, OP_CODE_MAX * 4 + 3));
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            // noise: ignored codes, not counted
            add_req(OP_W'($urandom_range(OP_DISPLAY + 1, OP_CODE_MAX)), pick_word(), pos,
                    drain);
         end else begin
            if (pick < 13)
               add_req(OP_DISPLAY, pick_word(), pos, drain);
            else if (pick < 23)
               add_req(OP_PEEK, pick_word(), pos, drain);
            else if (pick < 35)
               add_req(OP_CHANGE, pick_word(), pos, drain);
            else if ($urandom_range(0, 99) < push_bias)
               add_req(OP_PUSH, pick_word(), pos, drain);
            else
               add_req(OP_POP, pick_word(), pos, drain);
            counted++;
         end
      end

      // Synchronous reset, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every transaction and every response, then let the block settle
      while (accepted_count != total_reqs || awaited_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && awaited_rsp_q.size() == 0) begin
         $display("** lifo_stack_engine: PASSED **");
      end else begin
         $display("** lifo_stack_engine: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
design/lse_pkg.sv
design/lse_if.sv
design/lifo_stack_engine.sv
tb/sv/tb_top.sv
